/* hdl/heston_path_euler_step_macros.svh */
// Assertion macros shared by the Heston path step RTL.
`ifndef HESTON_PATH_EULER_STEP_MACROS_SVH
`define HESTON_PATH_EULER_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define HPES_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define HPES_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HPES_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HPES_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/hpes_pkg.sv */
// Types, constants and fixed-point helpers for the Heston path step block.
package hpes_pkg;

   localparam int DEF_MAX_PATHS = 1048576;

   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam logic [40:0] LN2_X256  = 41'd762123384832;
   localparam logic [30:0] Q_ONE     = 31'd16777216;
   localparam logic [51:0] SUM_MAX   = {52{1'b1}};
   localparam logic [30:0] POS_MAX   = {31{1'b1}};
   localparam int          SQ_STEPS  = 28;

   // register indexes
   localparam logic [2:0] CSR_RATE   = 3'd0;
   localparam logic [2:0] CSR_KAPPA  = 3'd1;
   localparam logic [2:0] CSR_THETA  = 3'd2;
   localparam logic [2:0] CSR_SIGMA  = 3'd3;
   localparam logic [2:0] CSR_RHO    = 3'd4;
   localparam logic [2:0] CSR_DT     = 3'd5;
   localparam logic [2:0] CSR_V0     = 3'd6;
   localparam logic [2:0] CSR_STRIKE = 3'd7;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQRT_DT,
      OP_MUL_RR,
      OP_SQRT_OMR,
      OP_MUL_Z1SDT,
      OP_MUL_RHOZ1,
      OP_MUL_S1RZ2,
      OP_MUL_CSDT,
      OP_SQRT_V,
      OP_MUL_DRIFT,
      OP_MUL_SVDW1,
      OP_MUL_KT,
      OP_MUL_TDT,
      OP_MUL_SVDW2,
      OP_MUL_SIGT,
      OP_EXP_INIT,
      OP_EXP_RED,
      OP_EXP_T1,
      OP_MUL_TERM,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_TERM_ACC,
      OP_EXP_FIN,
      OP_OUT
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SQDT, S_SQDT_W, S_RR, S_RR_W, S_SQOM, S_SQOM_W,
      S_Z1, S_RZ, S_SZ, S_SZ_W, S_CS, S_SQV, S_SQV_W,
      S_DR, S_SD1, S_KT, S_KT_W, S_TD, S_SD2, S_SD2_W, S_SG, S_SG_W,
      S_EXI, S_RED, S_T1, S_TM, S_TW, S_DIV, S_TA, S_EF, S_OUT
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] arg;   // reduction bit index or Taylor divisor
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic path_last;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (!v[33] && v[32:31] != 2'b00) r = 32'sh7FFFFFFF;
      else if (v[33] && v[32:31] != 2'b11) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // Q8.24 product: floor shift by 24, then saturate
   function automatic logic signed [31:0] mulq(input logic signed [65:0] p);
      logic [41:0] s;
      logic signed [31:0] r;
      s = p[65:24];
      if (!s[41] && s[40:31] != '0) r = 32'sh7FFFFFFF;
      else if (s[41] && s[40:31] != '1) r = 32'sh80000000;
      else r = s[31:0];
      return r;
   endfunction

endpackage

/* hdl/hpes_sqrt.sv */
// Iterative integer square root, floor(sqrt(x * 2^24)), one result bit per cycle.
`include "heston_path_euler_step_macros.svh"
module hpes_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] x,
   output logic        done,
   output logic [27:0] root
);
   import hpes_pkg::*;

   logic [55:0] rad_ff, rad_in;
   logic [31:0] rem_ff, rem_in;
   logic [27:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [31:0] rem_sh, trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[29:0], rad_ff[55:54]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = {1'b0, x, 24'd0};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[53:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[26:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[26:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(SQ_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

   `HPES_ASSERT_IMP(a_no_restart, clock, reset, start, !busy_ff)

endmodule

/* hdl/hpes_datapath.sv */
// Datapath: configuration, path state, shared multiplier, sqrt and exp units.
module hpes_datapath #(
   parameter int MAX_PATHS = hpes_pkg::DEF_MAX_PATHS
) (
   input  logic             clock,
   input  logic             reset,
   input  hpes_pkg::cmd_type cmd,
   output hpes_pkg::sts_type sts,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   input  logic [31:0]      req_tdata,
   input  logic             req_tlast,
   input  logic [0:0]       req_tuser,
   output logic [135:0]     rsp_tdata
);
   import hpes_pkg::*;

   localparam int CW = $clog2(MAX_PATHS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PATHS);

   // configuration
   logic signed [31:0] rate_ff;
   logic [30:0] kappa_ff, theta_ff, sigma_ff, v0_ff, strike_ff;
   logic signed [25:0] rho_ff;
   logic [24:0] dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= '0;
         kappa_ff  <= '0;
         theta_ff  <= '0;
         sigma_ff  <= '0;
         rho_ff    <= '0;
         dt_ff     <= '0;
         v0_ff     <= '0;
         strike_ff <= Q_ONE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE:   rate_ff   <= csr_wdata;
            CSR_KAPPA:  kappa_ff  <= csr_wdata[30:0];
            CSR_THETA:  theta_ff  <= csr_wdata[30:0];
            CSR_SIGMA:  sigma_ff  <= csr_wdata[30:0];
            CSR_RHO:    rho_ff    <= csr_wdata[25:0];
            CSR_DT:     dt_ff     <= csr_wdata[24:0];
            CSR_V0:     v0_ff     <= csr_wdata[30:0];
            CSR_STRIKE: strike_ff <= csr_wdata[30:0];
            default:    rate_ff   <= rate_ff;
         endcase
      end
   end

   // working registers
   logic signed [15:0] z1_ff, z1_in, z2_ff, z2_in;
   logic plast_ff, plast_in, blast_ff, blast_in;
   logic fresh_ff, fresh_in;
   logic signed [31:0] lp_ff, lp_in;
   logic [30:0] var_ff, var_in;
   logic [27:0] sdt_ff, sdt_in, s1r_ff, s1r_in, sv_ff, sv_in;
   logic [24:0] om_ff, om_in;
   logic signed [31:0] a_ff, a_in, c_ff, c_in, dw1_ff, dw1_in, dw2_ff, dw2_in;
   logic signed [31:0] drift_ff, drift_in, vd_ff, vd_in, t_ff, t_in;
   logic signed [65:0] prod_ff, prod_in;
   op_type opd_ff, opd_in, sqop_ff, sqop_in;
   logic [40:0] rem_ff, rem_in;
   logic [8:0]  q_ff, q_in;
   logic [31:0] term_ff, term_in, dn_ff, dn_in, dq_ff, dq_in;
   logic [3:0]  dr_ff, dr_in;
   logic [33:0] sum_ff, sum_in;
   logic [30:0] e_ff, e_in;
   logic [51:0] total_ff, total_in;
   logic [CW-1:0] pcnt_ff, pcnt_in;
   logic signed [31:0] olp_ff, olp_in;
   logic [30:0] opay_ff, opay_in;
   logic [51:0] osum_ff, osum_in;
   logic [20:0] ocnt_ff, ocnt_in;

   logic signed [32:0] mop_a, mop_b;
   logic signed [31:0] mq;
   logic sq_start, sq_done;
   logic [30:0] sq_x;
   logic [27:0] sq_root;

   hpes_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .x     (sq_x),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign sq_start = (cmd.op == OP_SQRT_DT) || (cmd.op == OP_SQRT_OMR) ||
                     (cmd.op == OP_SQRT_V);

   always_comb begin
      case (cmd.op)
         OP_SQRT_DT:  sq_x = {6'd0, dt_ff};
         OP_SQRT_OMR: sq_x = {6'd0, om_ff};
         default:     sq_x = var_ff;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      logic signed [32:0] z1s, z2s, rho_s;
      logic signed [31:0] dr;
      z1s   = {{5{z1_ff[15]}}, z1_ff, 12'd0};
      z2s   = {{5{z2_ff[15]}}, z2_ff, 12'd0};
      rho_s = {{7{rho_ff[25]}}, rho_ff};
      dr    = sat32({{2{rate_ff[31]}}, rate_ff} - {4'd0, var_ff[30:1]});
      mop_a = '0;
      mop_b = '0;
      case (cmd.op)
         OP_MUL_RR:    begin mop_a = rho_s;                mop_b = rho_s; end
         OP_MUL_Z1SDT: begin mop_a = z1s;                  mop_b = {5'd0, sdt_ff}; end
         OP_MUL_RHOZ1: begin mop_a = rho_s;                mop_b = z1s; end
         OP_MUL_S1RZ2: begin mop_a = {5'd0, s1r_ff};       mop_b = z2s; end
         OP_MUL_CSDT:  begin mop_a = {c_ff[31], c_ff};     mop_b = {5'd0, sdt_ff}; end
         OP_MUL_DRIFT: begin
            mop_a = {dr[31], dr};
            mop_b = {8'd0, dt_ff};
         end
         OP_MUL_SVDW1: begin mop_a = {5'd0, sv_ff};        mop_b = {dw1_ff[31], dw1_ff}; end
         OP_MUL_KT:    begin
            mop_a = {2'd0, kappa_ff};
            mop_b = {2'd0, theta_ff} - {2'd0, var_ff};
         end
         OP_MUL_TDT:   begin mop_a = {t_ff[31], t_ff};     mop_b = {8'd0, dt_ff}; end
         OP_MUL_SVDW2: begin mop_a = {5'd0, sv_ff};        mop_b = {dw2_ff[31], dw2_ff}; end
         OP_MUL_SIGT:  begin mop_a = {2'd0, sigma_ff};     mop_b = {t_ff[31], t_ff}; end
         OP_MUL_TERM:  begin mop_a = {1'b0, term_ff};      mop_b = {1'b0, rem_ff[31:0]}; end
         default:      begin mop_a = '0;                   mop_b = '0; end
      endcase
      prod_in = mop_a * mop_b;
   end

   assign mq = mulq(prod_ff);

   always_comb begin
      logic [33:0] omr, vsum;
      logic signed [31:0] vn;
      logic [40:0] trial;
      logic [4:0] r5;
      logic [3:0] drt;
      logic [31:0] dnt;
      logic [7:0] qb;
      logic [39:0] wide;
      logic [8:0] sh;
      logic [30:0] pay;
      logic [52:0] tot;
      logic [CW-1:0] pnext;
      logic [CW+20:0] pext;

      omr = '0; vsum = '0; vn = '0; trial = '0; r5 = '0; drt = '0; dnt = '0;
      qb = '0; wide = '0; sh = '0; pay = '0; tot = '0; pnext = '0; pext = '0;
      z1_in = z1_ff; z2_in = z2_ff; plast_in = plast_ff; blast_in = blast_ff;
      fresh_in = fresh_ff; lp_in = lp_ff; var_in = var_ff;
      sdt_in = sdt_ff; s1r_in = s1r_ff; sv_in = sv_ff; om_in = om_ff;
      a_in = a_ff; c_in = c_ff; dw1_in = dw1_ff; dw2_in = dw2_ff;
      drift_in = drift_ff; vd_in = vd_ff; t_in = t_ff;
      rem_in = rem_ff; q_in = q_ff; term_in = term_ff; dn_in = dn_ff; dq_in = dq_ff;
      dr_in = dr_ff; sum_in = sum_ff; e_in = e_ff; total_in = total_ff;
      pcnt_in = pcnt_ff; olp_in = olp_ff; opay_in = opay_ff; osum_in = osum_ff;
      ocnt_in = ocnt_ff;
      opd_in = cmd.op;
      sqop_in = sq_start ? cmd.op : sqop_ff;

      // multiplier writeback, in the cycle after issue
      case (opd_ff)
         OP_MUL_RR: begin
            omr = 34'(Q_ONE) - {{2{mq[31]}}, mq};
            om_in = omr[33] ? 25'd0 : omr[24:0];
         end
         OP_MUL_Z1SDT: dw1_in = mq;
         OP_MUL_RHOZ1: a_in = mq;
         OP_MUL_S1RZ2: c_in = sat32({{2{a_ff[31]}}, a_ff} + {{2{mq[31]}}, mq});
         OP_MUL_CSDT:  dw2_in = mq;
         OP_MUL_DRIFT: drift_in = mq;
         OP_MUL_SVDW1: lp_in = sat32({{2{lp_ff[31]}}, lp_ff} +
                                     {{2{drift_ff[31]}}, drift_ff} + {{2{mq[31]}}, mq});
         OP_MUL_KT:    t_in = mq;
         OP_MUL_TDT:   vd_in = mq;
         OP_MUL_SVDW2: t_in = mq;
         OP_MUL_SIGT: begin
            vsum = {3'd0, var_ff} + {{2{vd_ff[31]}}, vd_ff} + {{2{mq[31]}}, mq};
            vn = sat32(vsum);
            var_in = vn[31] ? 31'd0 : vn[30:0];
         end
         default: ;
      endcase

      if (sq_done) begin
         case (sqop_ff)
            OP_SQRT_DT:  sdt_in = sq_root;
            OP_SQRT_OMR: s1r_in = sq_root;
            default:     sv_in = sq_root;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            z1_in    = req_tdata[15:0];
            z2_in    = req_tdata[31:16];
            plast_in = req_tlast;
            blast_in = req_tuser[0];
            if (fresh_ff) begin
               lp_in    = '0;
               var_in   = v0_ff;
               fresh_in = 1'b0;
            end
         end
         OP_EXP_INIT: begin
            // offset by 256*ln2 keeps the dividend positive; quotient minus 256 is n
            rem_in = {{1{lp_ff[31]}}, lp_ff, 8'd0} + LN2_X256;
            q_in   = '0;
         end
         OP_EXP_RED: begin
            trial = {9'd0, LN2_Q32} << cmd.arg;
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               q_in[cmd.arg] = 1'b1;
            end
         end
         OP_EXP_T1: begin
            term_in = rem_ff[31:0];
            sum_in  = 34'h1_0000_0000 + {2'd0, rem_ff[31:0]};
         end
         OP_DIV_LOAD: begin
            dn_in = prod_ff[63:32];
            dq_in = '0;
            dr_in = '0;
         end
         OP_DIV_STEP: begin
            drt = dr_ff;
            dnt = dn_ff;
            qb  = '0;
            for (int i = 0; i < 8; i++) begin
               r5  = {drt, dnt[31]};
               dnt = {dnt[30:0], 1'b0};
               if (r5 >= {1'b0, cmd.arg}) begin
                  r5  = r5 - {1'b0, cmd.arg};
                  qb  = {qb[6:0], 1'b1};
               end else begin
                  qb  = {qb[6:0], 1'b0};
               end
               drt = r5[3:0];
            end
            dr_in = drt;
            dn_in = dnt;
            dq_in = {dq_ff[23:0], qb};
         end
         OP_TERM_ACC: begin
            term_in = dq_ff;
            sum_in  = sum_ff + {2'd0, dq_ff};
         end
         OP_EXP_FIN: begin
            if (q_ff >= 9'd263) begin
               e_in = POS_MAX;
            end else if (q_ff[8]) begin
               wide = {6'd0, sum_ff} << q_ff[2:0];
               e_in = wide[39] ? POS_MAX : wide[38:8];
            end else begin
               sh = 9'd264 - q_ff;
               wide = {6'd0, sum_ff} >> sh[5:0];
               e_in = (sh >= 9'd34) ? 31'd0 : wide[30:0];
            end
         end
         OP_OUT: begin
            pay   = (e_ff > strike_ff) ? (e_ff - strike_ff) : 31'd0;
            tot   = {1'b0, total_ff} + {22'd0, pay};
            pnext = (pcnt_ff < CNT_MAX) ? (pcnt_ff + CW'(1)) : pcnt_ff;
            pext  = {21'd0, pnext};
            olp_in  = lp_ff;
            opay_in = pay;
            osum_in = tot[52] ? SUM_MAX : tot[51:0];
            ocnt_in = pext[20:0];
            if (blast_ff) begin
               total_in = '0;
               pcnt_in  = '0;
            end else begin
               total_in = tot[52] ? SUM_MAX : tot[51:0];
               pcnt_in  = pnext;
            end
            fresh_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      z1_ff <= z1_in; z2_ff <= z2_in; plast_ff <= plast_in; blast_ff <= blast_in;
      lp_ff <= lp_in; var_ff <= var_in;
      sdt_ff <= sdt_in; s1r_ff <= s1r_in; sv_ff <= sv_in; om_ff <= om_in;
      a_ff <= a_in; c_ff <= c_in; dw1_ff <= dw1_in; dw2_ff <= dw2_in;
      drift_ff <= drift_in; vd_ff <= vd_in; t_ff <= t_in; prod_ff <= prod_in;
      rem_ff <= rem_in; q_ff <= q_in; term_ff <= term_in; dn_ff <= dn_in;
      dq_ff <= dq_in; dr_ff <= dr_in; sum_ff <= sum_in; e_ff <= e_in;
      olp_ff <= olp_in; opay_ff <= opay_in; osum_ff <= osum_in; ocnt_ff <= ocnt_in;
      sqop_ff <= sqop_in;
      if (reset) begin
         fresh_ff <= 1'b1;
         total_ff <= '0;
         pcnt_ff  <= '0;
         opd_ff   <= OP_NONE;
      end else begin
         fresh_ff <= fresh_in;
         total_ff <= total_in;
         pcnt_ff  <= pcnt_in;
         opd_ff   <= opd_in;
      end
   end

   assign sts.sqrt_done = sq_done;
   assign sts.path_last = plast_ff;
   assign rsp_tdata = {ocnt_ff, osum_ff, opay_ff, olp_ff};

endmodule

/* hdl/hpes_ctrl.sv */
// Step sequencer: walks the datapath through one Euler step and the payoff.
`include "heston_path_euler_step_macros.svh"
module hpes_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  hpes_pkg::sts_type sts,
   output hpes_pkg::cmd_type cmd
);
   import hpes_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in, k_ff, k_in;
   logic       vld_ff, vld_in;
   logic       out_held;

   assign out_held = vld_ff && !rsp_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      vld_in   = vld_ff && !rsp_tready;
      cmd.op   = OP_NONE;
      cmd.arg  = '0;
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            cmd.op   = OP_LOAD;
            state_in = S_SQDT;
         end
         S_SQDT:   begin cmd.op = OP_SQRT_DT; state_in = S_SQDT_W; end
         S_SQDT_W: if (sts.sqrt_done) state_in = S_RR;
         S_RR:     begin cmd.op = OP_MUL_RR; state_in = S_RR_W; end
         S_RR_W:   state_in = S_SQOM;
         S_SQOM:   begin cmd.op = OP_SQRT_OMR; state_in = S_SQOM_W; end
         S_SQOM_W: if (sts.sqrt_done) state_in = S_Z1;
         S_Z1:     begin cmd.op = OP_MUL_Z1SDT; state_in = S_RZ; end
         S_RZ:     begin cmd.op = OP_MUL_RHOZ1; state_in = S_SZ; end
         S_SZ:     begin cmd.op = OP_MUL_S1RZ2; state_in = S_SZ_W; end
         S_SZ_W:   state_in = S_CS;
         S_CS:     begin cmd.op = OP_MUL_CSDT; state_in = S_SQV; end
         S_SQV:    begin cmd.op = OP_SQRT_V; state_in = S_SQV_W; end
         S_SQV_W:  if (sts.sqrt_done) state_in = S_DR;
         S_DR:     begin cmd.op = OP_MUL_DRIFT; state_in = S_SD1; end
         S_SD1:    begin cmd.op = OP_MUL_SVDW1; state_in = S_KT; end
         S_KT:     begin cmd.op = OP_MUL_KT; state_in = S_KT_W; end
         S_KT_W:   state_in = S_TD;
         S_TD:     begin cmd.op = OP_MUL_TDT; state_in = S_SD2; end
         S_SD2:    begin cmd.op = OP_MUL_SVDW2; state_in = S_SD2_W; end
         S_SD2_W:  state_in = S_SG;
         S_SG:     begin cmd.op = OP_MUL_SIGT; state_in = S_SG_W; end
         S_SG_W:   state_in = sts.path_last ? S_EXI : S_IDLE;
         S_EXI: begin
            cmd.op   = OP_EXP_INIT;
            cnt_in   = 4'd8;
            state_in = S_RED;
         end
         S_RED: begin
            cmd.op  = OP_EXP_RED;
            cmd.arg = cnt_ff;
            if (cnt_ff == 4'd0) state_in = S_T1;
            else cnt_in = cnt_ff - 4'd1;
         end
         S_T1: begin
            cmd.op   = OP_EXP_T1;
            k_in     = 4'd2;
            state_in = S_TM;
         end
         S_TM: begin cmd.op = OP_MUL_TERM; state_in = S_TW; end
         S_TW: begin
            cmd.op   = OP_DIV_LOAD;
            cnt_in   = 4'd3;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op  = OP_DIV_STEP;
            cmd.arg = k_ff;
            if (cnt_ff == 4'd0) state_in = S_TA;
            else cnt_in = cnt_ff - 4'd1;
         end
         S_TA: begin
            cmd.op = OP_TERM_ACC;
            if (k_ff == 4'd12) state_in = S_EF;
            else begin
               k_in     = k_ff + 4'd1;
               state_in = S_TM;
            end
         end
         S_EF: begin cmd.op = OP_EXP_FIN; state_in = S_OUT; end
         S_OUT: if (!out_held) begin
            // output register is free or drains this cycle
            cmd.op   = OP_OUT;
            vld_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      k_ff   <= k_in;
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;

   `HPES_ASSERT_NXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `HPES_ASSERT_IMP(a_out_free, clock, reset, cmd.op == OP_OUT, !out_held)
   `HPES_ASSERT_NXT(a_out_valid, clock, reset, cmd.op == OP_OUT, rsp_tvalid)

endmodule

/* hdl/heston_path_euler_step.sv */
// Each step runs three iterative square roots; a path's last step also evaluates
// exp by range reduction and a Taylor series through the x^12/12! term.
// Items are taken one at a time; the next item is taken while a result waits.
// Reset (synchronous, active high) clears control, batch sum and count, and
// restores register defaults (strike ratio 1.0, others zero).
module heston_path_euler_step #(
   parameter int MAX_PATHS = hpes_pkg::DEF_MAX_PATHS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // z_price, z_variance
   input  logic         req_tlast,   // path_last
   input  logic [0:0]   req_tuser,   // batch_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // log_return, payoff_ratio, payoff_sum, path_count
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import hpes_pkg::*;

   cmd_type cmd;
   sts_type sts;

   hpes_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hpes_datapath #(.MAX_PATHS(MAX_PATHS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule
